/* rtl/pds_pkg.sv */
// Package for the PLL divider search unit: word types, widths, constants and states.
package pds_pkg;

  localparam int unsigned MULT_MIN_DEF     = 16;
  localparam int unsigned MULT_MAX_DEF     = 320;
  localparam int unsigned POST_DIV_MAX_DEF = 7;

  localparam int unsigned REF_W     = 24;
  localparam int unsigned TGT_W     = 21;
  localparam int unsigned TGT_HZ_W  = 31;
  localparam int unsigned PD_W      = 3;
  localparam int unsigned D_W       = 2 * PD_W;
  localparam int unsigned TPROD_W   = TGT_HZ_W + D_W;
  localparam int unsigned FB_MULT_W = 9;
  localparam int unsigned ACH_W     = 31;
  localparam int unsigned BOUND_W   = 34;

  localparam logic [REF_W-1:0]   REF_RESET_HZ    = 24'd12000000;
  localparam logic [9:0]         KHZ_TO_HZ       = 10'd1000;
  localparam logic [30:0]        VCO_MAX_HZ      = 31'd1600000000;
  localparam logic [30:0]        VCO_MIN_LOW_HZ  = 31'd400000000;
  localparam logic [30:0]        VCO_MIN_SPEC_HZ = 31'd750000000;
  localparam logic [BOUND_W-1:0] BOUND_HZ        = 34'd10000000000;

  localparam int unsigned        FB_MULT_BITS = 7;
  localparam logic [6:0]         FALLBACK_MULT = 7'd125;
  localparam logic [PD_W-1:0]    FALLBACK_PD1  = 3'd4;
  localparam logic [PD_W-1:0]    FALLBACK_PD2  = 3'd3;

  typedef struct packed {
    logic [TGT_W-1:0] target_khz;
    logic             prefer_low_jitter;
    logic             allow_below_spec;
  } pds_in_t;

  typedef struct packed {
    logic [FB_MULT_W-1:0] feedback_mult;
    logic [PD_W-1:0]      post_div_one;
    logic [PD_W-1:0]      post_div_two;
    logic [ACH_W-1:0]     achieved_hz;
    logic                 found;
  } pds_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VCO,
    ST_SCAN,
    ST_DRAIN,
    ST_PROD,
    ST_DIV,
    ST_DONE
  } pds_state_e;

endpackage

/* rtl/pll_divider_search_unit.sv */
// PLL feedback multiplier and post divider search, top level.
//
// One word in gives one word out. After a word is accepted, in_stall_o stays high until the
// result is loaded into the output register. The search walks the multipliers MULT_MIN..MULT_MAX,
// descending when prefer_low_jitter is set and ascending otherwise. A multiplier whose VCO lies
// outside the allowed window passes through the VCO and scan states and issues no candidate. A
// multiplier inside the window issues one candidate per scan cycle into the three-stage deviation
// pipeline, one for each post divider pair with post_div_one >= post_div_two up to POST_DIV_MAX.
// The search ends by draining the pipeline, forming the divide operands, REF_W + max(multiplier
// bits, 7) restoring divide steps (33 at defaults) and loading the output register. The scan loop
// over candidates takes the largest share of the time that a word takes.
// A new word may be accepted while the previous result still waits in the output register. The
// reference register is written through the config channel, which is always ready and must only
// be written while the unit is idle.
module pll_divider_search_unit
  import pds_pkg::*;
#(
  parameter int unsigned MULT_MIN     = MULT_MIN_DEF,
  parameter int unsigned MULT_MAX     = MULT_MAX_DEF,
  parameter int unsigned POST_DIV_MAX = POST_DIV_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [REF_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pds_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pds_out_t         out_data_o
);

  // widths derived from the multiplier range
  localparam int unsigned MULT_W  = $clog2(MULT_MAX + 1);
  localparam int unsigned BM_W    = (MULT_W > FB_MULT_BITS) ? MULT_W : FB_MULT_BITS;
  localparam int unsigned VCO_W   = (REF_W + MULT_W > 31) ? REF_W + MULT_W : 31;
  localparam int unsigned NUM_W0  = (VCO_W > TPROD_W) ? VCO_W : TPROD_W;
  localparam int unsigned NUM_W   = (NUM_W0 > BOUND_W) ? NUM_W0 : BOUND_W;
  localparam int unsigned CMP_W   = NUM_W + D_W;
  localparam int unsigned DVD_W   = REF_W + BM_W;
  localparam int unsigned CNT_W   = $clog2(DVD_W + 1);
  localparam bit          NO_MULT = (MULT_MAX < MULT_MIN);

  localparam logic [MULT_W-1:0] MULT_LO = MULT_W'(MULT_MIN);
  localparam logic [MULT_W-1:0] MULT_HI = MULT_W'(MULT_MAX);
  localparam logic [PD_W-1:0]   PD_LAST = PD_W'(POST_DIV_MAX);
  localparam logic [PD_W-1:0]   PD_ONE  = PD_W'(1);

  pds_state_e state_q, state_d;

  // configuration
  logic [REF_W-1:0] ref_q;

  // per-word setup
  logic [TGT_HZ_W-1:0] target_hz_q;
  logic                desc_q;
  logic [VCO_W-1:0]    vco_min_q;
  logic [MULT_W-1:0]   mult_q, mult_end_q;
  logic [VCO_W-1:0]    vco_q;
  logic [PD_W-1:0]     pd1_q, pd2_q;

  // deviation pipeline: s1 divider product, s2 target product, s3 deviation
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [D_W-1:0]    s1_d_q, s2_d_q, s3_d_q;
  logic [PD_W-1:0]   s1_pd1_q, s2_pd1_q, s3_pd1_q;
  logic [PD_W-1:0]   s1_pd2_q, s2_pd2_q, s3_pd2_q;
  logic [MULT_W-1:0] s1_mult_q, s2_mult_q, s3_mult_q;
  logic [VCO_W-1:0]  s1_vco_q, s2_vco_q;
  logic [TPROD_W-1:0] s2_tprod_q;
  logic [NUM_W-1:0]  s3_num_q;

  // best candidate so far
  logic [NUM_W-1:0]  best_num_q;
  logic [D_W-1:0]    best_den_q;
  logic [BM_W-1:0]   best_mult_q;
  logic [PD_W-1:0]   best_pd1_q, best_pd2_q;
  logic              found_q;

  // achieved frequency divider
  logic [DVD_W-1:0]  dvd_q;
  logic [D_W-1:0]    rem_q, div_d_q;
  logic [CNT_W-1:0]  cnt_q;

  // output register
  logic     out_valid_q;
  pds_out_t out_q;

  // control strobes
  logic accept, issue, next_mult, last_mult, pd_last, in_range, load_out, better;
  logic pipe_empty;
  logic [CMP_W-1:0] lhs, rhs;
  logic [D_W:0]     trial;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_range   = (vco_q <= VCO_W'(VCO_MAX_HZ)) && (vco_q >= vco_min_q);
  assign pd_last    = (pd1_q == PD_LAST) && (pd2_q == PD_LAST);
  assign last_mult  = (mult_q == mult_end_q);
  assign pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q;

  // exact rational compare: num/d < best_num/best_den
  assign lhs    = CMP_W'(s3_num_q) * CMP_W'(best_den_q);
  assign rhs    = CMP_W'(best_num_q) * CMP_W'(s3_d_q);
  assign better = s3_v_q && (lhs < rhs);

  assign trial = {rem_q, dvd_q[DVD_W-1]};

  always_comb begin
    state_d   = state_q;
    accept    = 1'b0;
    issue     = 1'b0;
    next_mult = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = NO_MULT ? ST_DRAIN : ST_VCO;
        end
      end
      ST_VCO: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        issue = in_range;
        if (!in_range || pd_last) begin
          if (last_mult) begin
            state_d = ST_DRAIN;
          end else begin
            next_mult = 1'b1;
            state_d   = ST_VCO;
          end
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_q       <= REF_RESET_HZ;
      out_valid_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        ref_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_hz_q <= TGT_HZ_W'(in_data_i.target_khz) * TGT_HZ_W'(KHZ_TO_HZ);
      desc_q      <= in_data_i.prefer_low_jitter;
      vco_min_q   <= in_data_i.allow_below_spec ? VCO_W'(VCO_MIN_LOW_HZ)
                                                 : VCO_W'(VCO_MIN_SPEC_HZ);
      mult_q      <= in_data_i.prefer_low_jitter ? MULT_HI : MULT_LO;
      mult_end_q  <= in_data_i.prefer_low_jitter ? MULT_LO : MULT_HI;
      best_num_q  <= NUM_W'(BOUND_HZ);
      best_den_q  <= D_W'(1);
      best_mult_q <= BM_W'(FALLBACK_MULT);
      best_pd1_q  <= FALLBACK_PD1;
      best_pd2_q  <= FALLBACK_PD2;
      found_q     <= 1'b0;
    end else if (better) begin
      best_num_q  <= s3_num_q;
      best_den_q  <= s3_d_q;
      best_mult_q <= BM_W'(s3_mult_q);
      best_pd1_q  <= s3_pd1_q;
      best_pd2_q  <= s3_pd2_q;
      found_q     <= 1'b1;
    end

    if (state_q == ST_VCO) begin
      vco_q <= VCO_W'(ref_q) * VCO_W'(mult_q);
      pd1_q <= PD_ONE;
      pd2_q <= PD_ONE;
    end else if (issue && !pd_last) begin
      if (pd1_q == PD_LAST) begin
        pd2_q <= pd2_q + PD_ONE;
        pd1_q <= pd2_q + PD_ONE;
      end else begin
        pd1_q <= pd1_q + PD_ONE;
      end
    end

    if (next_mult) begin
      mult_q <= desc_q ? mult_q - MULT_W'(1) : mult_q + MULT_W'(1);
    end

    // stage 1: divider product
    s1_d_q    <= D_W'(pd1_q) * D_W'(pd2_q);
    s1_pd1_q  <= pd1_q;
    s1_pd2_q  <= pd2_q;
    s1_mult_q <= mult_q;
    s1_vco_q  <= vco_q;
    // stage 2: target times divider product
    s2_tprod_q <= TPROD_W'(target_hz_q) * TPROD_W'(s1_d_q);
    s2_d_q     <= s1_d_q;
    s2_pd1_q   <= s1_pd1_q;
    s2_pd2_q   <= s1_pd2_q;
    s2_mult_q  <= s1_mult_q;
    s2_vco_q   <= s1_vco_q;
    // stage 3: absolute deviation scaled by the divider product
    s3_num_q  <= (NUM_W'(s2_vco_q) > NUM_W'(s2_tprod_q))
                 ? NUM_W'(s2_vco_q) - NUM_W'(s2_tprod_q)
                 : NUM_W'(s2_tprod_q) - NUM_W'(s2_vco_q);
    s3_d_q    <= s2_d_q;
    s3_pd1_q  <= s2_pd1_q;
    s3_pd2_q  <= s2_pd2_q;
    s3_mult_q <= s2_mult_q;

    // achieved frequency: restoring divide, quotient shifts into the dividend register
    if (state_q == ST_PROD) begin
      dvd_q   <= DVD_W'(ref_q) * DVD_W'(best_mult_q);
      div_d_q <= D_W'(best_pd1_q) * D_W'(best_pd2_q);
      rem_q   <= '0;
      cnt_q   <= CNT_W'(DVD_W);
    end else if (state_q == ST_DIV) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (trial >= {1'b0, div_d_q}) begin
        rem_q <= D_W'(trial - {1'b0, div_d_q});
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[D_W-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      end
    end

    if (load_out) begin
      out_q.feedback_mult <= FB_MULT_W'(best_mult_q);
      out_q.post_div_one  <= best_pd1_q;
      out_q.post_div_two  <= best_pd2_q;
      out_q.achieved_hz   <= ACH_W'(dvd_q);
      out_q.found         <= found_q;
    end
  end

  // the divide only starts once every candidate has been compared
  a_div_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> pipe_empty)
    else $error("divide started with candidates in flight");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_d_q))
    else $error("divider remainder out of range");

  // the held best triple keeps the first post divider at or above the second
  a_best_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (best_pd1_q >= best_pd2_q))
    else $error("best post dividers out of order");

  // a result without a searched triple carries the fallback dividers
  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |->
      (out_q.post_div_one == FALLBACK_PD1) && (out_q.post_div_two == FALLBACK_PD2))
    else $error("fallback word has wrong dividers");

endmodule
